// File: design/mlt_pkg.sv
// Shared types, codes and constants of the MAC learning table.
`timescale 1ns / 1ps
package mlt_pkg;

  // Request codes carried in req_type.
  localparam logic [2:0] REQ_LOOKUP    = 3'd0;
  localparam logic [2:0] REQ_LEARN     = 3'd1;
  localparam logic [2:0] REQ_DEL_KEY   = 3'd2;
  localparam logic [2:0] REQ_DEL_PORT  = 3'd3;
  localparam logic [2:0] REQ_DEL_VLAN  = 3'd4;
  localparam logic [2:0] REQ_DEL_VPORT = 3'd5;
  localparam logic [2:0] REQ_FLUSH     = 3'd6;
  localparam logic [2:0] REQ_TICK      = 3'd7;

  // Result status codes.
  localparam logic [1:0] STS_HIT  = 2'd0;
  localparam logic [1:0] STS_MISS = 2'd1;
  localparam logic [1:0] STS_FULL = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MIN_PERSIST = 2'd0;
  localparam logic [1:0] CFG_EXPIRE      = 2'd1;
  localparam logic [1:0] CFG_GC_INTERVAL = 2'd2;

  localparam logic [15:0] MIN_PERSIST_RST = 16'd3;
  localparam logic [15:0] EXPIRE_RST      = 16'd100;
  localparam logic [15:0] GC_INTERVAL_RST = 16'd2;

  localparam logic [31:0] HASH_MUL_X = 32'h0305_0709;
  localparam logic [31:0] HASH_MUL_Y = 32'h0b0d_1113;

  typedef enum logic [2:0] {
    SWP_ALL,
    SWP_PORT,
    SWP_VLAN,
    SWP_VLAN_PORT,
    SWP_AGE
  } sweep_kind_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [47:0] mac_addr;
    logic [11:0] vlan_id;
    logic [7:0]  port_num;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] port_out;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic        load;
    logic        hash;
    logic        scan_start;
    logic        ent_write;
    logic        sweep_start;
    sweep_kind_t sweep_kind;
    logic        tick;
    logic        out_load;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [2:0] req;
    logic       hit;
    logic       free;
    logic       scan_done;
    logic       sweep_done;
    logic       sweep_due;
    logic       out_free;
  } sts_t;

endpackage

// File: design/mlt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/mlt_ctrl.sv
// Request sequencer of the MAC learning table.
`timescale 1ns / 1ps
module mlt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  mlt_pkg::sts_t sts,
  output mlt_pkg::cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_INIT,
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_HASH,
    ST_HASH2,
    ST_SCAN,
    ST_WRITE,
    ST_SWEEP,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.sweep_kind = mlt_pkg::SWP_ALL;
    case (state_r)
      ST_INIT: begin
        cmd.sweep_start = 1'b1;
        state_nxt = ST_CLEAR;
      end
      ST_CLEAR: begin
        if (sts.sweep_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts.req)
          mlt_pkg::REQ_LOOKUP, mlt_pkg::REQ_LEARN, mlt_pkg::REQ_DEL_KEY: begin
            state_nxt = ST_HASH;
          end
          mlt_pkg::REQ_DEL_PORT: begin
            cmd.sweep_start = 1'b1;
            cmd.sweep_kind = mlt_pkg::SWP_PORT;
            state_nxt = ST_SWEEP;
          end
          mlt_pkg::REQ_DEL_VLAN: begin
            cmd.sweep_start = 1'b1;
            cmd.sweep_kind = mlt_pkg::SWP_VLAN;
            state_nxt = ST_SWEEP;
          end
          mlt_pkg::REQ_DEL_VPORT: begin
            cmd.sweep_start = 1'b1;
            cmd.sweep_kind = mlt_pkg::SWP_VLAN_PORT;
            state_nxt = ST_SWEEP;
          end
          mlt_pkg::REQ_FLUSH: begin
            cmd.sweep_start = 1'b1;
            state_nxt = ST_SWEEP;
          end
          default: begin
            cmd.tick = 1'b1;
            if (sts.sweep_due) begin
              cmd.sweep_start = 1'b1;
              cmd.sweep_kind = mlt_pkg::SWP_AGE;
              state_nxt = ST_SWEEP;
            end else begin
              state_nxt = ST_DONE;
            end
          end
        endcase
      end
      ST_HASH: begin
        cmd.hash = 1'b1;
        state_nxt = ST_HASH2;
      end
      ST_HASH2: begin
        cmd.scan_start = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          if ((sts.req == mlt_pkg::REQ_LEARN && (sts.hit || sts.free)) ||
              (sts.req == mlt_pkg::REQ_DEL_KEY && sts.hit)) begin
            state_nxt = ST_WRITE;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_WRITE: begin
        cmd.ent_write = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_SWEEP: begin
        if (sts.sweep_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

endmodule

// File: design/mlt_dpath.sv
// Datapath of the MAC learning table: configuration, hash, entry memory, scans and result.
`timescale 1ns / 1ps
module mlt_dpath #(
  parameter int BUCKET_BITS = 7,
  parameter int WAYS        = 8,
  parameter int PORT_BITS   = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mlt_pkg::in_item_t    in_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output mlt_pkg::out_item_t   out_data,
  input  logic                 cfg_wr_en,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  mlt_pkg::cmd_t        cmd,
  output mlt_pkg::sts_t        sts
);

  localparam int NENTRIES = (1 << BUCKET_BITS) * WAYS;
  localparam int ADDR_W   = $clog2(NENTRIES);
  localparam int WIDX_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ENT_W    = 1 + 48 + 12 + PORT_BITS + 32;
  localparam int PORT_LO  = 32;
  localparam int VLAN_LO  = PORT_LO + PORT_BITS;
  localparam int MAC_LO   = VLAN_LO + 12;

  // Configuration and time.
  logic [15:0] minp_r, expire_r, gc_r;
  logic [31:0] now_r;
  logic [15:0] cd_r;
  logic [15:0] cfg_gc_eff;
  logic [15:0] gc_eff;

  assign cfg_gc_eff = (cfg_data == 16'd0) ? 16'd1 : cfg_data;
  assign gc_eff     = (gc_r == 16'd0) ? 16'd1 : gc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      minp_r   <= mlt_pkg::MIN_PERSIST_RST;
      expire_r <= mlt_pkg::EXPIRE_RST;
      gc_r     <= mlt_pkg::GC_INTERVAL_RST;
      cd_r     <= mlt_pkg::GC_INTERVAL_RST;
      now_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          mlt_pkg::CFG_MIN_PERSIST: minp_r <= cfg_data;
          mlt_pkg::CFG_EXPIRE:      expire_r <= cfg_data;
          mlt_pkg::CFG_GC_INTERVAL: begin
            gc_r <= cfg_data;
            cd_r <= cfg_gc_eff;
          end
          default: ;
        endcase
      end
      if (cmd.tick) begin
        now_r <= now_r + 32'd1;
        cd_r  <= (cd_r <= 16'd1) ? gc_eff : cd_r - 16'd1;
      end
    end
  end

  // Latched item.
  mlt_pkg::in_item_t item_r;
  logic [11:0]          port12;
  logic [PORT_BITS-1:0] port_m;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
  end

  assign port12 = {4'b0, item_r.port_num};
  assign port_m = port12[PORT_BITS-1:0];

  // Bucket hash over two registered multiplies.
  logic [31:0] key_x, key_y, prod_x_r, prod_y_r, hsum, hfold;
  logic [ADDR_W-1:0] base_r;

  assign key_x = {item_r.mac_addr[23:16], item_r.mac_addr[31:24],
                  item_r.mac_addr[39:32], item_r.mac_addr[47:40]};
  assign key_y = {4'b0, item_r.vlan_id[11:8], item_r.vlan_id[7:0],
                  item_r.mac_addr[7:0], item_r.mac_addr[15:8]};
  assign hsum  = prod_x_r + prod_y_r;
  assign hfold = hsum ^ (hsum >> 12) ^ (hsum >> 8) ^ (hsum >> 4);

  always_ff @(posedge clk) begin
    if (cmd.hash) begin
      prod_x_r <= key_x * mlt_pkg::HASH_MUL_X;
      prod_y_r <= key_y * mlt_pkg::HASH_MUL_Y;
    end
    if (cmd.scan_start) begin
      base_r <= ADDR_W'(hfold[BUCKET_BITS-1:0] * WAYS);
    end
  end

  // Entry memory.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [ENT_W-1:0]  ram_wdata, rdata;

  mlt_ram #(
    .WIDTH(ENT_W),
    .DEPTH(NENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  logic                 d_valid;
  logic [47:0]          d_mac;
  logic [11:0]          d_vlan;
  logic [PORT_BITS-1:0] d_port;
  logic [31:0]          d_seen;

  assign d_valid = rdata[ENT_W-1];
  assign d_mac   = rdata[MAC_LO+47:MAC_LO];
  assign d_vlan  = rdata[VLAN_LO+11:VLAN_LO];
  assign d_port  = rdata[VLAN_LO-1:PORT_LO];
  assign d_seen  = rdata[31:0];

  // Bucket scan: one way read per cycle, each checked in the cycle after its read.
  logic                 scan_act_r, chk_vld_r;
  logic [WIDX_W-1:0]    rd_cnt_r, chk_way_r;
  logic                 hit_r, free_r;
  logic [WIDX_W-1:0]    hit_way_r, free_way_r;
  logic [PORT_BITS-1:0] hit_port_r;
  logic [31:0]          hit_seen_r;
  logic                 d_match;

  assign d_match = d_valid && (d_mac == item_r.mac_addr) && (d_vlan == item_r.vlan_id);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_act_r <= 1'b0;
      chk_vld_r  <= 1'b0;
    end else begin
      chk_vld_r <= scan_act_r;
      if (cmd.scan_start) begin
        scan_act_r <= 1'b1;
      end else if (scan_act_r && rd_cnt_r == WIDX_W'(WAYS - 1)) begin
        scan_act_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_way_r <= rd_cnt_r;
    if (cmd.scan_start) begin
      rd_cnt_r <= '0;
      hit_r    <= 1'b0;
      free_r   <= 1'b0;
    end else begin
      if (scan_act_r) begin
        rd_cnt_r <= rd_cnt_r + WIDX_W'(1);
      end
      if (chk_vld_r) begin
        if (d_match && !hit_r) begin
          hit_r      <= 1'b1;
          hit_way_r  <= chk_way_r;
          hit_port_r <= d_port;
          hit_seen_r <= d_seen;
        end
        if (!d_valid && !free_r) begin
          free_r     <= 1'b1;
          free_way_r <= chk_way_r;
        end
      end
    end
  end

  // Table sweep: read each entry, clear its valid bit in the cycle after if it qualifies.
  logic                 sw_act_r, sw_pend_r;
  logic [ADDR_W-1:0]    sw_cnt_r, sw_addr_r;
  mlt_pkg::sweep_kind_t sw_kind_r;
  logic                 sw_clear;
  logic [31:0]          d_idle;

  assign d_idle = now_r - d_seen;

  always_comb begin
    case (sw_kind_r)
      mlt_pkg::SWP_ALL:       sw_clear = 1'b1;
      mlt_pkg::SWP_PORT:      sw_clear = d_valid && (d_port == port_m);
      mlt_pkg::SWP_VLAN:      sw_clear = d_valid && (d_vlan == item_r.vlan_id);
      mlt_pkg::SWP_VLAN_PORT: sw_clear = d_valid && (d_vlan == item_r.vlan_id) &&
                                         (d_port == port_m);
      mlt_pkg::SWP_AGE:       sw_clear = d_valid && (d_idle > {16'b0, expire_r});
      default:                sw_clear = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_act_r  <= 1'b0;
      sw_pend_r <= 1'b0;
    end else begin
      sw_pend_r <= sw_act_r;
      if (cmd.sweep_start) begin
        sw_act_r <= 1'b1;
      end else if (sw_act_r && sw_cnt_r == ADDR_W'(NENTRIES - 1)) begin
        sw_act_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    sw_addr_r <= sw_cnt_r;
    if (cmd.sweep_start) begin
      sw_cnt_r  <= '0;
      sw_kind_r <= cmd.sweep_kind;
    end else if (sw_act_r) begin
      sw_cnt_r <= sw_cnt_r + ADDR_W'(1);
    end
  end

  // Entry update after a scan.
  logic [31:0]          hit_idle;
  logic [PORT_BITS-1:0] new_port;
  logic [WIDX_W-1:0]    wr_way;
  logic                 ent_valid;

  assign hit_idle  = now_r - hit_seen_r;
  assign new_port  = ((hit_port_r != port_m) && (hit_idle > {16'b0, minp_r})) ?
                     port_m : hit_port_r;
  assign wr_way    = hit_r ? hit_way_r : free_way_r;
  assign ent_valid = (item_r.req_type == mlt_pkg::REQ_LEARN);

  always_comb begin
    ram_raddr = scan_act_r ? ADDR_W'(base_r + ADDR_W'(rd_cnt_r)) : sw_cnt_r;
    if (sw_pend_r) begin
      ram_we    = sw_clear;
      ram_waddr = sw_addr_r;
      ram_wdata = {1'b0, rdata[ENT_W-2:0]};
    end else begin
      ram_we    = cmd.ent_write;
      ram_waddr = ADDR_W'(base_r + ADDR_W'(wr_way));
      ram_wdata = {ent_valid, item_r.mac_addr, item_r.vlan_id,
                   hit_r ? new_port : port_m, now_r};
    end
  end

  // Result register.
  logic [PORT_BITS+7:0] hit_port_ext, port_m_ext;
  mlt_pkg::out_item_t   res;
  logic                 out_valid_r;
  mlt_pkg::out_item_t   out_data_r;

  assign hit_port_ext = {8'b0, hit_port_r};
  assign port_m_ext   = {8'b0, port_m};

  always_comb begin
    res = '0;
    case (item_r.req_type)
      mlt_pkg::REQ_LOOKUP: begin
        res.status   = hit_r ? mlt_pkg::STS_HIT : mlt_pkg::STS_MISS;
        res.port_out = hit_r ? hit_port_ext[7:0] : 8'd0;
      end
      mlt_pkg::REQ_LEARN: begin
        if (hit_r) begin
          res.status   = mlt_pkg::STS_HIT;
          res.port_out = hit_port_ext[7:0];
        end else if (free_r) begin
          res.status   = mlt_pkg::STS_MISS;
          res.port_out = port_m_ext[7:0];
        end else begin
          res.status = mlt_pkg::STS_FULL;
        end
      end
      mlt_pkg::REQ_DEL_KEY: begin
        res.status = hit_r ? mlt_pkg::STS_HIT : mlt_pkg::STS_MISS;
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign sts.req        = item_r.req_type;
  assign sts.hit        = hit_r;
  assign sts.free       = free_r;
  assign sts.scan_done  = !scan_act_r && !chk_vld_r;
  assign sts.sweep_done = !sw_act_r && !sw_pend_r;
  assign sts.sweep_due  = (cd_r <= 16'd1);
  assign sts.out_free   = !out_valid_r || out_ready;

endmodule

// File: design/mac_learning_table.sv
// Top level of the MAC learning table: sequencer plus datapath.
//
//   Channel  Signals                            Moves
//   input    in_valid / in_ready / in_data      one request item
//   output   out_valid / out_ready / out_data   one result item per request
//   config   cfg_wr_en / cfg_index / cfg_data   one register write, no wait
//
// Lookup, learn and delete-key go from acceptance to result through decode, a hash
// step and a second hash step for the registered multiplies, one memory read per way,
// the check of the last way and the loading of the result, plus a write step when
// the entry changes. Per-port and per-VLAN deletes, flush, and a tick that ages the
// table sweep the whole table, one entry per cycle through the single read port and
// single write port of the entry memory; a plain tick goes from decode to its result.
// After reset the block clears every valid bit in one pass over the table and
// accepts no item until it is done; configuration writes still land.
// One item is in flight at a time. A finished result sits in the output register,
// and the next item is accepted while it waits; that item stalls at its end until
// the output register is free.
`timescale 1ns / 1ps
module mac_learning_table #(
  parameter int BUCKET_BITS = 7,
  parameter int WAYS        = 8,
  parameter int PORT_BITS   = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mlt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mlt_pkg::out_item_t out_data,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  mlt_pkg::cmd_t cmd;
  mlt_pkg::sts_t sts;

  // The sequencer owns the request flow and its state register; all other storage lives in the datapath.
  mlt_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  mlt_dpath #(
    .BUCKET_BITS(BUCKET_BITS),
    .WAYS       (WAYS),
    .PORT_BITS  (PORT_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

// File: design/mlt_checker.sv
// Port-level checks of the MAC learning table and their binding.
`timescale 1ns / 1ps
module mlt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input mlt_pkg::out_item_t out_data
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Only one item is worked on at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in flight");

  // The clearing pass keeps the input closed right after reset.
  a_reset_closed: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input open during clearing pass");

  // No status code beyond bucket full, and a full bucket reports no port.
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status != 2'd3 &&
      (out_data.status != mlt_pkg::STS_FULL || out_data.port_out == 8'd0))
    else $error("bad result status");

endmodule

bind mac_learning_table mlt_checker u_mlt_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
